// File: rtl/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg
// Shared constants and types for the sliding window average block.
// ----------------------------------------------------------------------------
package swa_pkg;

  localparam int MAX_WINDOW    = 256;
  localparam int SAMPLE_BITS   = 32;
  localparam int SUM_BITS      = 40;
  localparam int AVG_BITS      = 32;
  localparam int WIN_BITS      = 9;
  localparam int SLOT_BITS     = $clog2(MAX_WINDOW);
  localparam int CNT_BITS      = $clog2(MAX_WINDOW + 1);
  localparam int WINDOW_RESET  = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  // Work handed from the front part to the divider.
  typedef struct packed {
    logic signed [SUM_BITS-1:0] sum;
    logic        [CNT_BITS-1:0] count;
  } swa_entry_t;

endpackage

// File: rtl/sliding_window_average.sv
// ----------------------------------------------------------------------------
// sliding_window_average
// Boxcar moving average over signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Each accepted sample updates a ring of up to 256 samples and a 40-bit
// running sum; every sample yields one transaction with the running sum and
// the average (sum / samples held, truncated toward zero, 0 when none held).
// The front end reads the ring and then updates it for each sample, and hands
// its work through a 2-entry queue to a bit-serial divider that loads an
// entry, divides and then registers the result; the front end can take new
// samples while the divider is busy, until the queue is full.
// Writing window_length_i clears the stored samples and sum; do so only
// while the block is idle. Windows above 256 act as 256, a window of 0 keeps
// nothing. No clearing pass after reset is needed.
// ----------------------------------------------------------------------------
module sliding_window_average import swa_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          window_length_we_i,
  input  logic [WIN_BITS-1:0]           window_length_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [AVG_BITS-1:0]    average_o,
  output logic signed [SUM_BITS-1:0]    window_sum_o
);

  logic       push;
  swa_entry_t push_data;
  logic       queue_full;
  logic       pop;
  swa_entry_t pop_data;
  logic       queue_empty;

  swa_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .window_length_we_i (window_length_we_i),
    .window_length_i    (window_length_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .sample_i           (sample_i),
    .queue_full_i       (queue_full),
    .push_o             (push),
    .push_data_o        (push_data)
  );

  swa_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (queue_empty)
  );

  swa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (queue_empty),
    .pop_data_i   (pop_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .average_o    (average_o),
    .window_sum_o (window_sum_o)
  );

endmodule

// File: rtl/swa_front.sv
// ----------------------------------------------------------------------------
// swa_front
// Accepts samples, keeps the sample ring, held count and running sum, and
// queues (sum, count) for the divider.
// ----------------------------------------------------------------------------
module swa_front import swa_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          window_length_we_i,
  input  logic [WIN_BITS-1:0]           window_length_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          queue_full_i,
  output logic                          push_o,
  output swa_entry_t                    push_data_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic                          state_q, state_d;
  logic [WIN_BITS-1:0]           win_q;
  logic [SLOT_BITS-1:0]          wr_slot_q, wr_slot_d;
  logic [SLOT_BITS-1:0]          old_slot_q, old_slot_d;
  logic [CNT_BITS-1:0]           held_q, held_d;
  logic signed [SUM_BITS-1:0]    sum_q, sum_d;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] old_q;
  logic [SAMPLE_BITS-1:0]        ring_q [MAX_WINDOW];

  logic                 accept;
  logic [CNT_BITS-1:0]  win_eff;
  logic                 keep;
  logic                 evict;

  assign in_stall_o = (state_q != ST_IDLE) || queue_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Window above the ring depth saturates.
  assign win_eff = (win_q > WIN_BITS'(MAX_WINDOW)) ? CNT_BITS'(MAX_WINDOW)
                                                   : CNT_BITS'(win_q);
  assign keep    = (win_eff != '0);
  assign evict   = keep && (held_q >= win_eff);

  function automatic logic [SLOT_BITS-1:0] next_slot(input logic [SLOT_BITS-1:0] s);
    next_slot = (s == SLOT_BITS'(MAX_WINDOW - 1)) ? '0 : s + SLOT_BITS'(1);
  endfunction

  always_comb begin
    state_d    = state_q;
    wr_slot_d  = wr_slot_q;
    old_slot_d = old_slot_q;
    held_d     = held_q;
    sum_d      = sum_q;
    push_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (keep) begin
          sum_d     = sum_q + SUM_BITS'(sample_q)
                      - (evict ? SUM_BITS'(old_q) : SUM_BITS'(0));
          wr_slot_d = next_slot(wr_slot_q);
          if (evict) begin
            old_slot_d = next_slot(old_slot_q);
          end else begin
            held_d = held_q + CNT_BITS'(1);
          end
        end
        push_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign push_data_o.sum   = sum_d;
  assign push_data_o.count = held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      win_q      <= WIN_BITS'(WINDOW_RESET);
      wr_slot_q  <= '0;
      old_slot_q <= '0;
      held_q     <= '0;
      sum_q      <= '0;
    end else if (window_length_we_i) begin
      win_q      <= window_length_i;
      state_q    <= ST_IDLE;
      wr_slot_q  <= '0;
      old_slot_q <= '0;
      held_q     <= '0;
      sum_q      <= '0;
    end else begin
      state_q    <= state_d;
      wr_slot_q  <= wr_slot_d;
      old_slot_q <= old_slot_d;
      held_q     <= held_d;
      sum_q      <= sum_d;
    end
  end

  // Sample ring: oldest entry is read on accept, new one written in the next cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
      old_q    <= ring_q[old_slot_q];
    end
    if (state_q == ST_UPD && keep) begin
      ring_q[wr_slot_q] <= sample_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_BITS'(MAX_WINDOW))
    else $error("held count exceeds ring depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !window_length_we_i) |=> (held_q != '0) || (sum_q == '0))
    else $error("nonzero sum with nothing held");

endmodule

// File: rtl/swa_fifo.sv
// ----------------------------------------------------------------------------
// swa_fifo
// Short queue decoupling the sample front end from the divider.
// ----------------------------------------------------------------------------
module swa_fifo import swa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  swa_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output swa_entry_t pop_data_o,
  output logic       empty_o
);

  swa_entry_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q;
  logic [QPTR_BITS-1:0] rd_ptr_q;
  logic [QCNT_BITS-1:0] cnt_q;

  assign full_o     = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [QPTR_BITS-1:0] inc_ptr(input logic [QPTR_BITS-1:0] p);
    inc_ptr = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= inc_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= inc_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_BITS'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule

// File: rtl/swa_back.sv
// ----------------------------------------------------------------------------
// swa_back
// Bit-serial signed divide of the running sum by the held count, with the
// output register.
// ----------------------------------------------------------------------------
module swa_back import swa_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  swa_entry_t                    pop_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [AVG_BITS-1:0]    average_o,
  output logic signed [SUM_BITS-1:0]    window_sum_o
);

  localparam int STEP_BITS = $clog2(SUM_BITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [STEP_BITS-1:0]       step_q;
  logic [SUM_BITS-1:0]        dq_q;      // dividend shifting out, quotient in
  logic [CNT_BITS-1:0]        rem_q;
  logic [CNT_BITS-1:0]        div_q;
  logic                       neg_q;
  logic signed [SUM_BITS-1:0] sum_q;
  logic                       out_valid_q;
  logic signed [AVG_BITS-1:0] avg_q;
  logic signed [SUM_BITS-1:0] osum_q;

  logic [CNT_BITS:0]   trial;
  logic                qbit;
  logic [CNT_BITS-1:0] rem_next;
  logic [SUM_BITS-1:0] mag;
  logic [SUM_BITS-1:0] quot;
  logic                out_free;
  logic                load;

  assign trial    = {rem_q, dq_q[SUM_BITS-1]};
  assign qbit     = (trial >= {1'b0, div_q});
  assign rem_next = qbit ? CNT_BITS'(trial - {1'b0, div_q}) : CNT_BITS'(trial);

  assign mag  = pop_data_i.sum[SUM_BITS-1] ? SUM_BITS'(-pop_data_i.sum)
                                           : SUM_BITS'(pop_data_i.sum);
  assign quot = neg_q ? SUM_BITS'(-dq_q) : dq_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign load     = (state_q == ST_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!empty_i) state_d = ST_DIV;
      ST_DIV:  if (step_q == STEP_BITS'(1)) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dq_q   <= mag;
      rem_q  <= '0;
      div_q  <= pop_data_i.count;
      neg_q  <= pop_data_i.sum[SUM_BITS-1];
      sum_q  <= pop_data_i.sum;
      step_q <= STEP_BITS'(SUM_BITS);
    end else if (state_q == ST_DIV) begin
      dq_q   <= {dq_q[SUM_BITS-2:0], qbit};
      rem_q  <= rem_next;
      step_q <= step_q - STEP_BITS'(1);
    end
    if (load) begin
      avg_q  <= (div_q == '0) ? '0 : AVG_BITS'(quot);
      osum_q <= sum_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign average_o    = avg_q;
  assign window_sum_o = osum_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && div_q == '0) |=> (average_o == '0))
    else $error("average nonzero with nothing held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < div_q) || (div_q == '0))
    else $error("partial remainder not below divisor");

endmodule
